// File: rtl/cwc_pkg.sv
// ----------------------------------------------------------------------------
// cwc_pkg
// Shared types and constants for the congestion window controller.
// ----------------------------------------------------------------------------
package cwc_pkg;

  localparam int IDX_W  = 16;  // packet index width
  localparam int WIN_W  = 7;   // window and threshold width
  localparam int DUP_W  = 2;   // duplicate ack counter width
  localparam int CIDX_W = 1;   // config register index width

  localparam logic [DUP_W-1:0] DUP_TRIGGER = 2'd3;
  localparam logic [WIN_W-1:0] RETX_BONUS  = 7'd3;
  localparam logic [WIN_W-1:0] THRESH_RST  = 7'd32;
  localparam logic [IDX_W-1:0] TOTAL_RST   = 16'd1;

  localparam logic [CIDX_W-1:0] REG_TOTAL_PACKETS     = 1'd0;
  localparam logic [CIDX_W-1:0] REG_INITIAL_THRESHOLD = 1'd1;

  localparam logic KIND_SEND = 1'b0;
  localparam logic KIND_RETX = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ACK,
    ST_SETUP,
    ST_SEND
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic latch;     // capture accepted request
    logic do_ack;    // apply ack update
    logic do_setup;  // set up send round
    logic emit;      // load next window index into output register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic retx;       // pending ack will cause a fast retransmit
    logic send_none;  // send round has nothing to emit
    logic emit_last;  // next emitted index is the final one
    logic out_free;   // output register can take a result this cycle
  } status_t;

endpackage

// File: rtl/cwc_ctrl.sv
// ----------------------------------------------------------------------------
// cwc_ctrl
// Sequencer: accepts a request, then runs the ack update or the send round.
// ----------------------------------------------------------------------------
module cwc_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             event_valid,
  input  logic             action,
  output logic             event_stall,
  input  cwc_pkg::status_t status,
  output cwc_pkg::cmd_t    cmd
);
  import cwc_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (event_valid) begin
          state_next = action ? ST_SETUP : ST_ACK;
        end
      end
      ST_ACK: begin
        if (!status.retx || status.out_free) begin
          state_next = ST_IDLE;
        end
      end
      ST_SETUP: begin
        state_next = status.send_none ? ST_IDLE : ST_SEND;
      end
      ST_SEND: begin
        if (status.out_free && status.emit_last) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd         = '0;
    event_stall = 1'b1;
    case (state)
      ST_IDLE: begin
        event_stall = 1'b0;
        cmd.latch   = event_valid;
      end
      ST_ACK:   cmd.do_ack   = !status.retx || status.out_free;
      ST_SETUP: cmd.do_setup = 1'b1;
      ST_SEND:  cmd.emit     = status.out_free;
      default: begin
        cmd         = '0;
        event_stall = 1'b1;
      end
    endcase
  end

endmodule

// File: rtl/cwc_dp.sv
// ----------------------------------------------------------------------------
// cwc_dp
// Window state, config registers, ack/send arithmetic and output register.
// ----------------------------------------------------------------------------
module cwc_dp #(
  parameter int MAX_WINDOW = 64
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wr,
  input  logic [cwc_pkg::CIDX_W-1:0]  cfg_index,
  input  logic [cwc_pkg::IDX_W-1:0]   cfg_data,
  input  logic [cwc_pkg::IDX_W-1:0]   ack_index,
  input  logic                        end_signal,
  input  logic                        receive_empty,
  input  cwc_pkg::cmd_t               cmd,
  output cwc_pkg::status_t            status,
  input  logic                        tx_stall,
  output logic                        tx_valid,
  output logic                        kind,
  output logic [cwc_pkg::IDX_W-1:0]   packet_index,
  output logic [cwc_pkg::WIN_W-1:0]   window_now,
  output logic                        last
);
  import cwc_pkg::*;

  localparam logic [WIN_W-1:0] MAX_W = WIN_W'(MAX_WINDOW);

  // config; initial_threshold only matters through slow_start_limit
  logic [IDX_W-1:0] total_packets;

  // window state
  logic [IDX_W-1:0] window_base;
  logic             have_ack;   // highest_ack valid (reset value is "none")
  logic [IDX_W-1:0] highest_ack;
  logic [WIN_W-1:0] window_size;
  logic [WIN_W-1:0] slow_start_limit;
  logic [DUP_W-1:0] duplicate_count;
  logic             finished;

  // latched request
  logic [IDX_W-1:0] req_ack;
  logic             req_end;
  logic             req_empty;

  // send round walker
  logic [IDX_W-1:0] cur;
  logic [IDX_W-1:0] end_idx;

  logic             is_new, is_dup;
  logic [DUP_W-1:0] dup_inc;
  logic [WIN_W-1:0] half_win, retx_win, grown, win_ack;
  logic [WIN_W:0]   retx_sum;
  logic [IDX_W:0]   end_sum;
  logic [IDX_W-1:0] end_clip;
  logic             load;

  assign grown    = (window_size >= MAX_W) ? MAX_W : window_size + 1'b1;
  assign is_new   = !have_ack || (req_ack > highest_ack);
  assign is_dup   = have_ack && (req_ack == highest_ack);
  assign dup_inc  = duplicate_count + 1'b1;
  assign half_win = window_size >> 1;
  assign retx_sum = {1'b0, half_win} + {1'b0, RETX_BONUS};
  assign retx_win = (retx_sum > {1'b0, MAX_W}) ? MAX_W : retx_sum[WIN_W-1:0];

  always_comb begin
    win_ack = window_size;
    if (is_new) begin
      if (window_size < slow_start_limit) begin
        win_ack = grown;
      end
    end else if (is_dup && dup_inc >= DUP_TRIGGER) begin
      win_ack = retx_win;
    end
    if (req_empty) begin
      win_ack = WIN_W'(1);
    end
  end

  assign end_sum  = {1'b0, window_base} + (IDX_W+1)'(window_size);
  assign end_clip = (end_sum > {1'b0, total_packets}) ? total_packets : end_sum[IDX_W-1:0];

  assign status.retx      = !req_end && !is_new && is_dup && (dup_inc >= DUP_TRIGGER);
  assign status.send_none = finished || (window_base >= end_clip);
  assign status.emit_last = ({1'b0, cur} + 1'b1) == {1'b0, end_idx};
  assign status.out_free  = !tx_valid || !tx_stall;

  assign load = cmd.emit || (cmd.do_ack && status.retx);

  // config registers and window state
  always_ff @(posedge clk) begin
    if (rst) begin
      total_packets     <= TOTAL_RST;
      window_base       <= '0;
      have_ack          <= 1'b0;
      highest_ack       <= '0;
      window_size       <= WIN_W'(1);
      slow_start_limit  <= THRESH_RST;
      duplicate_count   <= '0;
      finished          <= 1'b0;
    end else begin
      if (cfg_wr) begin
        case (cfg_index)
          REG_TOTAL_PACKETS: total_packets <= cfg_data;
          REG_INITIAL_THRESHOLD: begin
            slow_start_limit  <= cfg_data[WIN_W-1:0];
          end
          default: ;
        endcase
      end
      if (cmd.do_ack) begin
        if (req_end) begin
          finished <= 1'b1;
        end else begin
          window_size <= win_ack;
          if (is_new) begin
            window_base <= req_ack;
            highest_ack <= req_ack;
            have_ack    <= 1'b1;
          end else if (is_dup) begin
            if (dup_inc >= DUP_TRIGGER) begin
              slow_start_limit <= half_win;
              duplicate_count  <= '0;
            end else begin
              duplicate_count <= dup_inc;
            end
          end
        end
      end
      if (cmd.do_setup && !finished && (slow_start_limit < window_size)) begin
        window_size <= grown;
      end
    end
  end

  // request capture and walker (payload, no reset)
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      req_ack   <= ack_index;
      req_end   <= end_signal;
      req_empty <= receive_empty;
    end
    if (cmd.do_setup) begin
      cur     <= window_base;
      end_idx <= end_clip;
    end else if (cmd.emit) begin
      cur <= cur + 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      tx_valid <= 1'b0;
    end else if (load) begin
      tx_valid <= 1'b1;
    end else if (!tx_stall) begin
      tx_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (cmd.emit) begin
        kind         <= KIND_SEND;
        packet_index <= cur;
        window_now   <= window_size;
        last         <= status.emit_last;
      end else begin
        kind         <= KIND_RETX;
        packet_index <= req_ack;
        window_now   <= win_ack;
        last         <= 1'b1;
      end
    end
  end

  // window stays within 1..MAX_WINDOW
  a_win_range: assert property (@(posedge clk) disable iff (rst)
    window_size != '0 && window_size <= MAX_W)
    else $error("window size out of range");

  // counter is cleared on reaching the trigger
  a_dup_bound: assert property (@(posedge clk) disable iff (rst)
    duplicate_count != DUP_TRIGGER)
    else $error("duplicate counter left at trigger value");

  // never overwrite a result still waiting downstream
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    load |-> (!tx_valid || !tx_stall))
    else $error("output register overrun");

  // walker stays inside the clipped window
  a_walk_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (cur < end_idx))
    else $error("send index beyond window end");

  // a final send result ends the round
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    cmd.emit && status.emit_last |=> !cmd.emit)
    else $error("send continued after last index");

endmodule

// File: rtl/congestion_window_controller.sv
// ----------------------------------------------------------------------------
// congestion_window_controller
// Sender-side sliding window with Reno-style congestion control.
// ----------------------------------------------------------------------------
// One request is handled at a time. An ack request frees the block for the
// next acceptance after its update (later only while a fast retransmit
// waits for the output register to drain). A send round walks the n indices
// of the clipped window (n up to MAX_WINDOW): a set-up step, then one index
// per cycle through the single output register, so downstream stall
// stretches the round. The next request is taken while the final result
// still sits in the output register. Config writes are always ready and
// must only be issued while idle; writing initial_threshold also reloads the
// slow start limit.
// ----------------------------------------------------------------------------
module congestion_window_controller #(
  parameter int MAX_WINDOW = 64
) (
  input  logic                        clk,
  input  logic                        rst,
  // config write
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [cwc_pkg::CIDX_W-1:0]  cfg_index,
  input  logic [cwc_pkg::IDX_W-1:0]   cfg_data,
  // event requests
  input  logic                        event_valid,
  output logic                        event_stall,
  input  logic                        action,
  input  logic [cwc_pkg::IDX_W-1:0]   ack_index,
  input  logic                        end_signal,
  input  logic                        receive_empty,
  // transmit results
  output logic                        tx_valid,
  input  logic                        tx_stall,
  output logic                        kind,
  output logic [cwc_pkg::IDX_W-1:0]   packet_index,
  output logic [cwc_pkg::WIN_W-1:0]   window_now,
  output logic                        last
);
  import cwc_pkg::*;

  cmd_t    cmd;
  status_t status;

  assign cfg_ready = 1'b1;

  cwc_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .event_valid (event_valid),
    .action      (action),
    .event_stall (event_stall),
    .status      (status),
    .cmd         (cmd)
  );

  cwc_dp #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr        (cfg_valid && cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .ack_index     (ack_index),
    .end_signal    (end_signal),
    .receive_empty (receive_empty),
    .cmd           (cmd),
    .status        (status),
    .tx_stall      (tx_stall),
    .tx_valid      (tx_valid),
    .kind          (kind),
    .packet_index  (packet_index),
    .window_now    (window_now),
    .last          (last)
  );

endmodule

// File: tb/tb_congestion_window_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_congestion_window_controller
// Self-checking bench for the Reno-style congestion window controller.
// Ack and send-round requests are queued per phase, driven with random gaps,
// and predicted as they are accepted. Transmit results are compared field by
// field in arrival order. Register writes happen only when the block is idle.
// ----------------------------------------------------------------------------
module tb_congestion_window_controller;
  import cwc_pkg::*;

  localparam int MAX_WIN      = 64;
  localparam int LIMIT_CYCLES = 1_000_000;
  localparam int SETTLE       = 8;
  localparam logic ACT_ACK    = 1'b0;
  localparam logic ACT_SEND   = 1'b1;

  typedef struct {
    logic             act;
    logic [IDX_W-1:0] ack;
    logic             fin;
    logic             empty;
    bit               after_drain;  // hold back until every result is in
  } req_t;

  typedef struct {
    logic             kind;
    logic [IDX_W-1:0] idx;
    logic [WIN_W-1:0] win;
    logic             last;
  } tx_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CIDX_W-1:0] cfg_index = '0;
  logic [IDX_W-1:0] cfg_data = '0;
  logic event_valid = 1'b0;
  logic event_stall;
  logic action = 1'b0;
  logic [IDX_W-1:0] ack_index = '0;
  logic end_signal = 1'b0;
  logic receive_empty = 1'b0;
  logic tx_valid;
  logic tx_stall = 1'b0;
  logic kind;
  logic [IDX_W-1:0] packet_index;
  logic [WIN_W-1:0] window_now;
  logic last;

  congestion_window_controller #(.MAX_WINDOW(MAX_WIN)) u_top (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .event_valid(event_valid), .event_stall(event_stall), .action(action),
    .ack_index(ack_index), .end_signal(end_signal), .receive_empty(receive_empty),
    .tx_valid(tx_valid), .tx_stall(tx_stall), .kind(kind), .packet_index(packet_index),
    .window_now(window_now), .last(last)
  );

  always #5 clk = ~clk;

  // predictor state
  logic [IDX_W-1:0] snd_base;
  int               top_ack;
  logic [WIN_W-1:0] cwnd;
  logic [WIN_W-1:0] ssthresh;
  logic [DUP_W-1:0] dup_acks;
  bit               xfer_done;
  logic [IDX_W-1:0] total_pkts;

  req_t req_q[$];
  tx_t  tx_due_q[$];
  int   reqs_queued;
  int   reqs_taken;
  int   results_seen;
  int   retx_seen;
  int   cfg_writes;
  int   mismatches;
  int   cycles;
  logic [IDX_W-1:0] cur_ack;
  bit   idle_on;
  bit   hold_req;

  function automatic logic [WIN_W-1:0] grow(input logic [WIN_W-1:0] w);
    return (w >= MAX_WIN) ? WIN_W'(MAX_WIN) : w + 7'd1;
  endfunction

  function automatic void predict_tx(input req_t r);
    int unsigned stop;
    bit retx;
    retx = 1'b0;
    if (r.act == ACT_ACK) begin
      if (r.fin) begin
        xfer_done = 1'b1;
        return;
      end
      if (top_ack < int'(r.ack)) begin
        snd_base = r.ack;
        top_ack  = int'(r.ack);
        if (cwnd < ssthresh) cwnd = grow(cwnd);
      end else if (top_ack == int'(r.ack)) begin
        dup_acks = dup_acks + 2'd1;  // wraps like the 2-bit counter
        if (dup_acks >= DUP_TRIGGER) begin
          retx     = 1'b1;
          ssthresh = cwnd >> 1;
          cwnd     = ssthresh + RETX_BONUS;
          if (cwnd > MAX_WIN) cwnd = WIN_W'(MAX_WIN);
          dup_acks = '0;
        end
      end
      if (r.empty) cwnd = 7'd1;
      if (retx) tx_due_q.insert(tx_due_q.size(), tx_t'{KIND_RETX, r.ack, cwnd, 1'b1});
    end else if (!xfer_done) begin
      stop = snd_base + cwnd;
      if (stop > total_pkts) stop = total_pkts;
      if (ssthresh < cwnd) cwnd = grow(cwnd);
      for (int unsigned i = snd_base; i < stop; i++)
        tx_due_q.insert(tx_due_q.size(),
                        tx_t'{KIND_SEND, i[IDX_W-1:0], cwnd, (i + 1 == stop)});
    end
  endfunction

  function automatic void queue_req(input logic act, input logic [IDX_W-1:0] ack,
                                    input logic fin, input logic empty,
                                    input bit after_drain);
    req_q.insert(req_q.size(), req_t'{act, ack, fin, empty, after_drain});
    reqs_queued++;
  endfunction

  // mostly well-formed ack/send traffic with random content, some noise
  task automatic queue_traffic(input int n, input int send_pct);
    int r;
    int k;
    k = 0;
    while (k < n) begin
      r = $urandom_range(0, 99);
      if (r < send_pct) begin
        // ack index, end and empty flags are ignored on a send round
        queue_req(ACT_SEND, IDX_W'($urandom), 1'($urandom), 1'($urandom), 1'b0);
      end else if (r < send_pct + 12) begin
        repeat (3) queue_req(ACT_ACK, cur_ack, 1'b0, ($urandom_range(0, 19) == 0), 1'b0);
        k += 2;
      end else if (r < send_pct + 22) begin
        queue_req(ACT_ACK, cur_ack, 1'b0, ($urandom_range(0, 19) == 0), 1'b0);
      end else if (r < send_pct + 28) begin
        queue_req(ACT_ACK, IDX_W'($urandom_range(0, cur_ack)), 1'b0, 1'($urandom), 1'b0);
      end else begin
        if (cur_ack < 16'hFF00) cur_ack = cur_ack + IDX_W'($urandom_range(1, 6));
        queue_req(ACT_ACK, cur_ack, 1'b0, ($urandom_range(0, 19) == 0), 1'b0);
      end
      k++;
    end
  endtask

  task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [IDX_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cfg_writes++;
    if (idx == REG_TOTAL_PACKETS) begin
      total_pkts = val;
    end else if (idx == REG_INITIAL_THRESHOLD) begin
      ssthresh = val[WIN_W-1:0];
    end
  endtask

  // acks leave no result behind, so keep waiting after the last one is taken
  task automatic wait_idle();
    while (reqs_taken != reqs_queued || tx_due_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // request driver
  always @(posedge clk) begin : drv
    bit busy;
    req_t nxt;
    int gap;
    int calm;
    if (rst) begin
      event_valid <= 1'b0;
      gap  = 0;
      calm = 0;
    end else begin
      busy = event_valid;
      if (event_valid && !event_stall) begin
        predict_tx(nxt);
        reqs_taken++;
        busy = 1'b0;
        if (calm > 0) calm--;
        else if (idle_on && $urandom_range(0, 63) == 0) calm = $urandom_range(20, 80);
        else if (idle_on && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 4);
      end
      if (!busy) begin
        if (gap > 0) begin
          gap--;
        end else if (req_q.size() != 0 &&
                     (!req_q[0].after_drain || tx_due_q.size() == 0)) begin
          nxt = req_q.pop_front();
          action        <= nxt.act;
          ack_index     <= nxt.ack;
          end_signal    <= nxt.fin;
          receive_empty <= nxt.empty;
          busy = 1'b1;
        end
      end
      event_valid <= busy;
    end
  end

  // receiver stall, with one long hold-off on request
  always @(posedge clk) begin : rcv
    int hold_left;
    int burst_left;
    int calm;
    bit stall_nxt;
    if (rst) begin
      tx_stall  <= 1'b0;
      hold_left  = 0;
      burst_left = 0;
      calm       = 0;
    end else begin
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        stall_nxt = 1'b1;
      end else if (burst_left > 0) begin
        burst_left--;
        stall_nxt = 1'b1;
      end else if (calm > 0) begin
        calm--;
        stall_nxt = 1'b0;
      end else if (idle_on && $urandom_range(0, 63) == 0) begin
        calm = $urandom_range(20, 80);
        stall_nxt = 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        burst_left = $urandom_range(0, 3);
        stall_nxt = 1'b1;
      end else begin
        stall_nxt = 1'b0;
      end
      tx_stall <= stall_nxt;
    end
  end

  // result checker
  always @(posedge clk) begin : mon
    tx_t e;
    if (!rst && tx_valid && !tx_stall) begin
      results_seen++;
      if (kind == KIND_RETX) retx_seen++;
      if (tx_due_q.size() == 0) begin
        $display("%0t: unexpected result: kind %0d packet_index %0d window_now %0d last %0d",
                 $time, kind, packet_index, window_now, last);
        mismatches++;
      end else begin
        e = tx_due_q.pop_front();
        if (kind !== e.kind) begin
          $display("%0t: kind mismatch: expected %0d, actual %0d", $time, e.kind, kind);
          mismatches++;
        end
        if (packet_index !== e.idx) begin
          $display("%0t: packet_index mismatch: expected %0d, actual %0d",
                   $time, e.idx, packet_index);
          mismatches++;
        end
        if (window_now !== e.win) begin
          $display("%0t: window_now mismatch: expected %0d, actual %0d",
                   $time, e.win, window_now);
          mismatches++;
        end
        if (last !== e.last) begin
          $display("%0t: last mismatch: expected %0d, actual %0d", $time, e.last, last);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycles, tx_due_q.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    int tot;
    snd_base   = '0;
    top_ack    = -1;
    cwnd       = 7'd1;
    ssthresh   = THRESH_RST;
    dup_acks   = '0;
    xfer_done  = 1'b0;
    total_pkts = TOTAL_RST;
    cur_ack    = '0;
    idle_on    = 1'b1;
    hold_req   = 1'b0;
    reqs_queued = 0; reqs_taken = 0; results_seen = 0; retx_seen = 0;
    cfg_writes = 0; mismatches = 0; cycles = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // reset settings: a single-packet transfer, clipping on the second round
    queue_req(ACT_SEND, 16'h0000, 1'b0, 1'b0, 1'b0);
    queue_req(ACT_ACK, 16'h0000, 1'b0, 1'b0, 1'b0);
    queue_req(ACT_SEND, 16'hFFFF, 1'b1, 1'b1, 1'b0);
    wait_idle();

    write_reg(REG_TOTAL_PACKETS, 16'hFFFF);
    write_reg(REG_INITIAL_THRESHOLD, 16'd1);
    // triple duplicate, send, empty receive, older ack, halving down to zero
    repeat (3) queue_req(ACT_ACK, 16'h0000, 1'b0, 1'b0, 1'b0);
    queue_req(ACT_SEND, 16'h0000, 1'b0, 1'b0, 1'b0);
    queue_req(ACT_ACK, 16'h0003, 1'b0, 1'b1, 1'b0);
    queue_req(ACT_ACK, 16'h0001, 1'b0, 1'b0, 1'b0);
    repeat (2) queue_req(ACT_ACK, 16'h0003, 1'b0, 1'b0, 1'b0);
    queue_req(ACT_SEND, 16'h5A5A, 1'b0, 1'b0, 1'b0);
    queue_req(ACT_ACK, 16'h0003, 1'b0, 1'b0, 1'b0);
    queue_req(ACT_SEND, 16'hA5A5, 1'b0, 1'b0, 1'b0);
    cur_ack = 16'h0003;
    wait_idle();

    write_reg(REG_TOTAL_PACKETS, 16'd600);
    write_reg(REG_INITIAL_THRESHOLD, 16'd16);
    queue_traffic(50, 40);
    queue_req(ACT_SEND, 16'h0000, 1'b0, 1'b0, 1'b1);
    queue_traffic(50, 40);
    wait_idle();

    write_reg(REG_TOTAL_PACKETS, 16'hFFFF);
    write_reg(REG_INITIAL_THRESHOLD, 16'd64);
    queue_traffic(100, 35);
    hold_req = 1'b1;
    wait_idle();

    tot = int'(cur_ack) + $urandom_range(1, 80);
    if (tot > 65535) tot = 65535;
    write_reg(REG_TOTAL_PACKETS, IDX_W'(tot));
    write_reg(REG_INITIAL_THRESHOLD, IDX_W'($urandom_range(1, 64)));
    queue_traffic(100, 45);
    wait_idle();

    // closing stretch runs at full rate
    idle_on = 1'b0;
    write_reg(REG_TOTAL_PACKETS, 16'hFFFF);
    write_reg(REG_INITIAL_THRESHOLD, 16'd1);
    queue_traffic(80, 60);
    // top ack leaves nothing to send; then finish and keep acking
    queue_req(ACT_ACK, 16'hFFFF, 1'b0, 1'b0, 1'b0);
    queue_req(ACT_SEND, 16'h0000, 1'b0, 1'b0, 1'b0);
    repeat (3) queue_req(ACT_ACK, 16'hFFFF, 1'b0, 1'b0, 1'b0);
    queue_req(ACT_ACK, IDX_W'($urandom), 1'b1, 1'b1, 1'b0);
    queue_req(ACT_SEND, 16'h0000, 1'b0, 1'b0, 1'b0);
    repeat (3) queue_req(ACT_ACK, 16'hFFFF, 1'b0, 1'b0, 1'b0);
    queue_req(ACT_SEND, 16'h0000, 1'b0, 1'b0, 1'b0);
    wait_idle();

    $display("Covered %0d ack/send requests and %0d register writes over %0d cycles",
             reqs_taken, cfg_writes, cycles);
    $display("Checked %0d transmits (%0d fast retransmits), %0d mismatches",
             results_seen, retx_seen, mismatches);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/cwc_pkg.sv
rtl/cwc_ctrl.sv
rtl/cwc_dp.sv
rtl/congestion_window_controller.sv
tb/tb_congestion_window_controller.sv
